FILE: hdl/rshe_pkg.sv
// shared types, constants and register codes for the reorder spread hold estimator
package rshe_pkg;

	localparam int FRACTION_BITS_DEF = 8;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int HALF_LATENCY_FACTOR = 500;

	localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_WINDOW = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EWMA_SHIFT = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPREAD_CAP = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LATENCY = 4'd3;

	localparam logic [23:0] BUCKET_WINDOW_RST = 24'd20000;
	localparam logic [3:0] EWMA_SHIFT_RST = 4'd3;
	localparam logic [31:0] SPREAD_CAP_RST = 32'd100000;
	localparam logic [15:0] LATENCY_RST = 16'd120;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] send_ts;
		logic [62:0] arrival_us;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] hold_us;
		logic        bucket_closed;
	} out_beat_t;

	typedef struct packed {
		logic clear;
		logic closed;
	} step_ctrl_t;

endpackage

FILE: hdl/reorder_spread_hold_estimator.sv
// top level of the reorder spread hold estimator
// usage:
//   in channel (in_valid/in_ready/in_data) takes one beat per cycle unless stalled: a packet
//   observation with sender timestamp and arrival time, or a clear request.
//   out channel (out_valid/out_ready/out_data) gives exactly one beat per input
//   beat, in order: the latency-limited hold and a bucket-closed flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the bucket
//   window, smoothing shift, spread cap and latency; always ready, write
//   only while no beat is in flight.
// pipeline:
//   four register stages (tracker, smoothing, spread clamp, latency limit);
//   a beat passes through them in that order, and one beat can be accepted
//   every cycle while the output is not stalled.
// reset:
//   arst_n clears all estimator state and loads the register defaults.
// stall:
//   each stage holds when the next one is full and stalled, so bubbles are
//   squeezed out and the input keeps accepting until all four stages are full.
module reorder_spread_hold_estimator #(
	parameter int FRACTION_BITS = rshe_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rshe_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rshe_pkg::out_beat_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rshe_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rshe_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rshe_pkg::*;

	logic [23:0] window_q;
	logic [3:0]  shift_q;
	logic [31:0] cap_q;
	logic [15:0] latency_q;
	logic [31:0] half_q;

	logic v1_s1, v2_s2, v3_s3, vo_q;
	logic r2, r3, ro;
	logic take1, take2, take3, take_o;

	step_ctrl_t  trk_ctrl;
	logic [63:0] trk_bmin, trk_bmax;
	step_ctrl_t  ctrl_s1;
	logic [63:0] bmin_s1, bmax_s1;

	logic [63:0] ew_smin, ew_smax;
	step_ctrl_t  ctrl_s2;
	logic [63:0] smin_s2, smax_s2;

	logic [31:0] stored_q;
	logic [63:0] spread;
	logic [63:0] whole;
	logic [31:0] clamped;
	logic [31:0] stored_n;
	logic [31:0] hold_s3;
	logic        closed_s3;
	logic [31:0] limited;
	out_beat_t   out_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= BUCKET_WINDOW_RST;
			shift_q <= EWMA_SHIFT_RST;
			cap_q <= SPREAD_CAP_RST;
			latency_q <= LATENCY_RST;
			half_q <= 32'(LATENCY_RST * HALF_LATENCY_FACTOR);
		end else begin
			half_q <= 32'(latency_q * HALF_LATENCY_FACTOR);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BUCKET_WINDOW: window_q <= cfg_data[23:0];
					REG_EWMA_SHIFT: shift_q <= cfg_data[3:0];
					REG_SPREAD_CAP: cap_q <= cfg_data[31:0];
					REG_LATENCY: latency_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// pipeline flow
	assign ro = !vo_q || out_ready;
	assign r3 = !v3_s3 || ro;
	assign r2 = !v2_s2 || r3;
	assign in_ready = !v1_s1 || r2;
	assign take1 = in_valid && in_ready;
	assign take2 = v1_s1 && r2;
	assign take3 = v2_s2 && r3;
	assign take_o = v3_s3 && ro;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (in_ready) v1_s1 <= in_valid;
			if (r2) v2_s2 <= v1_s1;
			if (r3) v3_s3 <= v2_s2;
			if (ro) vo_q <= v3_s3;
		end
	end

	// stage 1: delay tracking
	rshe_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take1),
		.beat   (in_data),
		.window (window_q),
		.ctrl   (trk_ctrl),
		.bmin   (trk_bmin),
		.bmax   (trk_bmax)
	);

	always_ff @(posedge clk) begin
		if (take1) begin
			ctrl_s1 <= trk_ctrl;
			bmin_s1 <= trk_bmin;
			bmax_s1 <= trk_bmax;
		end
	end

	// stage 2: smoothing
	rshe_ewma #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_ewma (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take2),
		.ctrl   (ctrl_s1),
		.bmin   (bmin_s1),
		.bmax   (bmax_s1),
		.shift  (shift_q),
		.smin   (ew_smin),
		.smax   (ew_smax)
	);

	always_ff @(posedge clk) begin
		if (take2) begin
			ctrl_s2 <= ctrl_s1;
			smin_s2 <= ew_smin;
			smax_s2 <= ew_smax;
		end
	end

	// stage 3: spread clamp and stored hold
	assign spread = smax_s2 - smin_s2;
	assign whole = spread >> FRACTION_BITS;

	always_comb begin
		if (spread[63]) begin
			clamped = '0;
		end else if (whole > {32'd0, cap_q}) begin
			clamped = cap_q;
		end else begin
			clamped = whole[31:0];
		end
		if (ctrl_s2.clear) begin
			stored_n = '0;
		end else if (ctrl_s2.closed) begin
			stored_n = clamped;
		end else begin
			stored_n = stored_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
		end else if (take3) begin
			stored_q <= stored_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take3) begin
			hold_s3 <= stored_n;
			closed_s3 <= ctrl_s2.closed;
		end
	end

	// stage 4: latency limit into the output register
	always_comb begin
		limited = hold_s3;
		if (half_q != 32'd0 && hold_s3 > half_q) begin
			limited = half_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take_o) begin
			out_q.hold_us <= limited;
			out_q.bucket_closed <= closed_s3;
		end
	end

	assign out_valid = vo_q;
	assign out_data = out_q;

`ifndef SYNTHESIS
	a_hold_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && half_q != 32'd0) |-> (out_data.hold_us <= half_q))
		else $error("hold above latency limit");

	a_clear_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(take1 && in_data.kind == KIND_CLEAR) |=> (v1_s1 && ctrl_s1.clear))
		else $error("clear beat lost in stage 1");

	a_clear_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 |-> !(ctrl_s1.clear && ctrl_s1.closed))
		else $error("clear beat marked as bucket close");
`endif

endmodule

FILE: hdl/rshe_track.sv
// delay tracker: timestamp accumulation, relative delay and bucket min/max
module rshe_track (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  rshe_pkg::in_beat_t beat,
	input  logic [23:0]      window,
	output rshe_pkg::step_ctrl_t ctrl,
	output logic [63:0]      bmin,
	output logic [63:0]      bmax
);
	import rshe_pkg::*;

	logic        init_q;
	logic        has_q;
	logic [31:0] last_ts_q;
	logic [63:0] base_q;
	logic [63:0] bstart_q;
	logic [63:0] bmin_q;
	logic [63:0] bmax_q;

	logic [63:0] arr;
	logic [31:0] d32;
	logic [63:0] delta;
	logic [63:0] rel;
	logic [63:0] elapsed;
	logic        is_clear;
	logic        is_first;
	logic        closed;

	assign arr = {1'b0, beat.arrival_us};
	assign d32 = beat.send_ts - last_ts_q;
	assign delta = {{32{d32[31]}}, d32};
	assign rel = arr - base_q - delta;
	assign elapsed = arr - bstart_q;
	assign is_clear = (beat.kind == KIND_CLEAR);
	assign is_first = !is_clear && !init_q;
	assign closed = !is_clear && init_q && !($signed(elapsed) < $signed({40'd0, window}));

	always_comb begin
		bmin = bmin_q;
		bmax = bmax_q;
		if (!has_q) begin
			bmin = rel;
			bmax = rel;
		end else begin
			if ($signed(rel) < $signed(bmin_q)) begin
				bmin = rel;
			end
			if ($signed(bmax_q) < $signed(rel)) begin
				bmax = rel;
			end
		end
	end

	assign ctrl.clear = is_clear;
	assign ctrl.closed = closed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			has_q <= 1'b0;
			last_ts_q <= '0;
			base_q <= '0;
			bmin_q <= '0;
			bmax_q <= '0;
		end else if (take) begin
			if (is_clear) begin
				init_q <= 1'b0;
				has_q <= 1'b0;
				last_ts_q <= '0;
				base_q <= '0;
				bmin_q <= '0;
				bmax_q <= '0;
			end else if (is_first) begin
				init_q <= 1'b1;
				last_ts_q <= beat.send_ts;
				base_q <= arr;
			end else begin
				last_ts_q <= beat.send_ts;
				base_q <= base_q + delta;
				bmin_q <= bmin;
				bmax_q <= bmax;
				has_q <= !closed;
			end
		end
	end

	// bucket start is read only after the first packet writes it
	always_ff @(posedge clk) begin
		if (take && !is_clear && (is_first || closed)) begin
			bstart_q <= arr;
		end
	end

endmodule

FILE: hdl/rshe_ewma.sv
// fixed-point smoothing of the bucket minimum and maximum
module rshe_ewma #(
	parameter int FRACTION_BITS = rshe_pkg::FRACTION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  rshe_pkg::step_ctrl_t ctrl,
	input  logic [63:0]      bmin,
	input  logic [63:0]      bmax,
	input  logic [3:0]       shift,
	output logic [63:0]      smin,
	output logic [63:0]      smax
);
	import rshe_pkg::*;

	logic        sv_q;
	logic [63:0] smin_q;
	logic [63:0] smax_q;

	logic [63:0] tmin;
	logic [63:0] tmax;
	logic [63:0] dmin;
	logic [63:0] dmax;

	assign tmin = bmin << FRACTION_BITS;
	assign tmax = bmax << FRACTION_BITS;
	assign dmin = tmin - smin_q;
	assign dmax = tmax - smax_q;

	always_comb begin
		smin = smin_q;
		smax = smax_q;
		if (ctrl.clear) begin
			smin = '0;
			smax = '0;
		end else if (ctrl.closed) begin
			if (!sv_q) begin
				smin = tmin;
				smax = tmax;
			end else begin
				smin = smin_q + 64'($signed(dmin) >>> shift);
				smax = smax_q + 64'($signed(dmax) >>> shift);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q <= 1'b0;
			smin_q <= '0;
			smax_q <= '0;
		end else if (take) begin
			smin_q <= smin;
			smax_q <= smax;
			if (ctrl.clear) begin
				sv_q <= 1'b0;
			end else if (ctrl.closed) begin
				sv_q <= 1'b1;
			end
		end
	end

endmodule
